// ----- sv/vlcs_pkg.sv -----
// Shared types and constants for the voice-link connection supervisor.
// Depends on nothing; imported by voice_link_connection_supervisor_core.
package vlcs_pkg;

    // Default width of the millisecond counters
    localparam int unsigned COUNTER_WIDTH_DEF = 16;

    // Width of the period registers the counters are compared against
    localparam int unsigned PERIOD_W = 16;

    // Milliseconds drained from the receive window at each poll
    localparam logic [16:0] RX_DRAIN = 17'd100;

    // Config port geometry
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 16;

    // Link state codes
    typedef enum logic [1:0] {
        LINK_DISC       = 2'd0,
        LINK_CONNECTING = 2'd1,
        LINK_CONNECTED  = 2'd2
    } t_link_mode;

    // Event codes carried in the cmd field
    typedef enum logic [2:0] {
        CMD_CONNECT    = 3'd0,
        CMD_ACCEPT     = 3'd1,
        CMD_DISCONNECT = 3'd2,
        CMD_BYE_RX     = 3'd3,
        CMD_DESC_RX    = 3'd4,
        CMD_AUDIO_RX   = 3'd5,
        CMD_TICK       = 3'd6
    } t_cmd;

    // Config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEEP_ALIVE_PERIOD   = 3'd0,
        REG_CONNECTION_TIMEOUT  = 3'd1,
        REG_MAX_CONNECT_RETRIES = 3'd2,
        REG_AUDIO_BLOCK_TIME    = 3'd3,
        REG_RECEIVE_SLACK       = 3'd4,
        REG_RECEIVE_MAX_WINDOW  = 3'd5,
        REG_RECEIVE_POLL_PERIOD = 3'd6
    } t_reg_idx;

endpackage

// ----- sv/voice_link_connection_supervisor_core.sv -----
// Voice-link connection supervisor: link state, keep-alive/timeout timers and
// receive-activity window, one event item per cycle. Depends on vlcs_pkg.
//
//  channel   | dir | handshake             | payload (from bit 0)
//  ----------+-----+-----------------------+--------------------------------------
//  s_axis    | in  | tvalid/tready         | cmd[2:0], send_ok[3], zero[7:4]
//  m_axis    | out | tvalid/tready         | ok, send_description, send_bye,
//            |     |                       | send_station_info, link_state[5:4],
//            |     |                       | state_changed, receiving,
//            |     |                       | receiving_changed, flush_audio, zero
//  i_cfg_*   | in  | write enable, no wait | 16-bit data, index 0..6
//
// Each item passes through the input register and then the result register,
// and one item is taken per cycle while the result register is not stalled;
// the single state-update pass between the two registers sets that rate.
// Synchronous active-low reset clears link state, timers and both stages and
// loads the config defaults. A stalled result register holds the input
// register, which then holds s_axis_tready low.
module voice_link_connection_supervisor_core #(
    parameter int unsigned COUNTER_WIDTH = vlcs_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [vlcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // cmd[2:0], send_ok[3]
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [vlcs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // ok, desc, bye, info,
                                                               // link_state[5:4], chg,
                                                               // rx, rx_chg, flush
    // config writes
    input  logic                               i_cfg_wr_en,
    input  logic [vlcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vlcs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import vlcs_pkg::*;

    // compare width covers both the counters and the 16-bit periods
    localparam int unsigned CMP_W =
        (COUNTER_WIDTH > PERIOD_W) ? COUNTER_WIDTH : PERIOD_W;

    typedef logic [COUNTER_WIDTH-1:0] t_cnt;

    // saturating increment
    function automatic t_cnt bump(input t_cnt c);
        t_cnt res;
        res = (c == '1) ? c : c + t_cnt'(1);
        return res;
    endfunction

    // config registers
    logic [15:0] r_keep_alive_period;
    logic [15:0] r_connection_timeout;
    logic [7:0]  r_max_connect_retries;
    logic [11:0] r_audio_block_time;
    logic [13:0] r_receive_slack;
    logic [14:0] r_receive_max_window;
    logic [15:0] r_receive_poll_period;

    // link state
    t_link_mode  r_mode,          n_mode;
    logic        r_timers_run,    n_timers_run;
    t_cnt        r_ka_elapsed,    n_ka_elapsed;
    t_cnt        r_to_elapsed,    n_to_elapsed;
    logic [7:0]  r_retry_count,   n_retry_count;
    logic        r_rx_active,     n_rx_active;
    t_cnt        r_poll_elapsed,  n_poll_elapsed;
    logic [16:0] r_window_left,   n_window_left;

    // input and result stages
    logic        r_in_valid;
    t_cmd        r_in_cmd;
    logic        r_in_send_ok;
    logic        r_out_valid;
    logic [OUT_TDATA_W-1:0] n_out_data, r_out_data;

    logic        adv;
    logic        n_ok, n_desc, n_bye, n_rxchg, n_flush, n_drop;
    logic        ka_hit, to_hit, poll_hit;
    logic [17:0] win_sum;
    logic [14:0] win_floor;

    // pipeline handshake
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // incremented counts against their periods
    assign ka_hit   = CMP_W'(bump(r_ka_elapsed))   >= CMP_W'(r_keep_alive_period);
    assign to_hit   = CMP_W'(bump(r_to_elapsed))   >= CMP_W'(r_connection_timeout);
    assign poll_hit = CMP_W'(bump(r_poll_elapsed)) >= CMP_W'(r_receive_poll_period);

    // one event applied to the link state
    always_comb begin
        n_mode         = r_mode;
        n_timers_run   = r_timers_run;
        n_ka_elapsed   = r_ka_elapsed;
        n_to_elapsed   = r_to_elapsed;
        n_retry_count  = r_retry_count;
        n_rx_active    = r_rx_active;
        n_poll_elapsed = r_poll_elapsed;
        n_window_left  = r_window_left;
        n_ok    = 1'b1;
        n_desc  = 1'b0;
        n_bye   = 1'b0;
        n_rxchg = 1'b0;
        n_flush = 1'b0;
        n_drop  = 1'b0;
        win_sum   = 18'(r_window_left) + 18'(r_audio_block_time);
        win_floor = 15'(r_audio_block_time) + 15'(r_receive_slack);

        unique case (r_in_cmd)
            CMD_CONNECT, CMD_ACCEPT: begin
                if (r_mode == LINK_DISC) begin
                    if (r_in_cmd == CMD_CONNECT) n_retry_count = '0;
                    n_desc = 1'b1;
                    n_ok   = r_in_send_ok;
                    if (r_in_send_ok) begin
                        n_timers_run = 1'b1;
                        n_ka_elapsed = '0;
                        n_to_elapsed = '0;
                        n_mode = (r_in_cmd == CMD_CONNECT) ? LINK_CONNECTING
                                                           : LINK_CONNECTED;
                    end
                end
            end
            CMD_DISCONNECT: begin
                if (r_mode != LINK_DISC) begin
                    n_bye  = 1'b1;
                    n_ok   = r_in_send_ok;
                    n_drop = r_in_send_ok;
                end
            end
            CMD_BYE_RX: begin
                if (r_mode != LINK_DISC) n_drop = 1'b1;
                else                     n_bye  = 1'b1;
            end
            CMD_DESC_RX: begin
                if (r_mode == LINK_CONNECTING)  n_mode       = LINK_CONNECTED;
                else if (r_mode == LINK_DISC)   n_bye        = 1'b1;
                else                            n_to_elapsed = '0;
            end
            CMD_AUDIO_RX: begin
                if (r_mode != LINK_DISC) begin
                    // reception start opens the window at the slack plus the audio block time
                    if (!r_rx_active) begin
                        n_rx_active    = 1'b1;
                        n_rxchg        = 1'b1;
                        n_poll_elapsed = '0;
                        win_sum = 18'(r_receive_slack) + 18'(r_audio_block_time);
                    end
                    if (win_sum < 18'(win_floor))
                        n_window_left = 17'(win_floor);
                    else if (win_sum > 18'(r_receive_max_window))
                        n_window_left = 17'(r_receive_max_window);
                    else
                        n_window_left = win_sum[16:0];
                end
            end
            CMD_TICK: begin
                // keep-alive first, then timeout, then receive poll
                if (r_timers_run) begin
                    n_ka_elapsed = bump(r_ka_elapsed);
                    if (ka_hit) begin
                        n_ka_elapsed = '0;
                        if (r_mode == LINK_CONNECTING) begin
                            n_retry_count = r_retry_count + 8'd1;
                            if (n_retry_count == r_max_connect_retries) n_drop = 1'b1;
                        end
                        if (!n_drop) n_desc = 1'b1;
                    end
                    if (!n_drop) begin
                        n_to_elapsed = bump(r_to_elapsed);
                        if (to_hit) n_drop = 1'b1;
                    end
                end
                if (!n_drop && r_rx_active) begin
                    n_poll_elapsed = bump(r_poll_elapsed);
                    if (poll_hit) begin
                        n_poll_elapsed = '0;
                        if (r_window_left <= RX_DRAIN) begin
                            n_rx_active   = 1'b0;
                            n_window_left = '0;
                            n_rxchg       = 1'b1;
                            n_flush       = 1'b1;
                        end else begin
                            n_window_left = r_window_left - RX_DRAIN;
                        end
                    end
                end
            end
            default: ;
        endcase

        // link teardown: ends reception and stops the timers
        if (n_drop) begin
            if (r_rx_active) begin
                n_rx_active    = 1'b0;
                n_poll_elapsed = '0;
                n_window_left  = '0;
                n_rxchg        = 1'b1;
                n_flush        = 1'b1;
            end
            n_timers_run = 1'b0;
            n_ka_elapsed = '0;
            n_to_elapsed = '0;
            n_mode       = LINK_DISC;
        end

        n_out_data = {6'd0, n_flush, n_rxchg, n_rx_active, (n_mode != r_mode),
                      n_mode,
                      (n_mode == LINK_CONNECTED && r_mode != LINK_CONNECTED),
                      n_bye, n_desc, n_ok};
    end

    // config, state and stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_alive_period   <= 16'd10000;
            r_connection_timeout  <= 16'd50000;
            r_max_connect_retries <= 8'd5;
            r_audio_block_time    <= 12'd80;
            r_receive_slack       <= 14'd500;
            r_receive_max_window  <= 15'd1000;
            r_receive_poll_period <= 16'd100;
            r_mode         <= LINK_DISC;
            r_timers_run   <= 1'b0;
            r_ka_elapsed   <= '0;
            r_to_elapsed   <= '0;
            r_retry_count  <= '0;
            r_rx_active    <= 1'b0;
            r_poll_elapsed <= '0;
            r_window_left  <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_KEEP_ALIVE_PERIOD:   r_keep_alive_period   <= i_cfg_wdata;
                    REG_CONNECTION_TIMEOUT:  r_connection_timeout  <= i_cfg_wdata;
                    REG_MAX_CONNECT_RETRIES: r_max_connect_retries <= i_cfg_wdata[7:0];
                    REG_AUDIO_BLOCK_TIME:    r_audio_block_time    <= i_cfg_wdata[11:0];
                    REG_RECEIVE_SLACK:       r_receive_slack       <= i_cfg_wdata[13:0];
                    REG_RECEIVE_MAX_WINDOW:  r_receive_max_window  <= i_cfg_wdata[14:0];
                    REG_RECEIVE_POLL_PERIOD: r_receive_poll_period <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (adv) begin
                r_mode         <= n_mode;
                r_timers_run   <= n_timers_run;
                r_ka_elapsed   <= n_ka_elapsed;
                r_to_elapsed   <= n_to_elapsed;
                r_retry_count  <= n_retry_count;
                r_rx_active    <= n_rx_active;
                r_poll_elapsed <= n_poll_elapsed;
                r_window_left  <= n_window_left;
            end
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (adv)                r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd     <= t_cmd'(s_axis_tdata[2:0]);
            r_in_send_ok <= s_axis_tdata[3];
        end
        if (adv) r_out_data <= n_out_data;
    end

endmodule
